// File: src/lsgm_pkg.sv
package lsgm_pkg;

  localparam int CFG_W = 13;
  localparam int GAP_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int GRP_OUT_W = 6;
  localparam int NEAR_W = GAP_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_GAP = 2'd2;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 13'd1024;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd1024;
  localparam logic [GAP_W-1:0] GROUP_GAP_RST = 8'd6;

  localparam int AXIS_SLACK = 5;
  localparam int EDGE_MARGIN = 10;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
    logic     key_sel;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EMPTY,
    ST_SORT_MAIN,
    ST_GROUP,
    ST_SORT_CROSS,
    ST_EMIT
  } state_t;

endpackage

// File: src/lsgm_cell.sv
module lsgm_cell
  import lsgm_pkg::*;
#(
  parameter int IDX = 0,
  parameter int N = 64,
  parameter int CB = 12,
  parameter int OW = 6,
  localparam int RW = 2 + 2 * OW + 4 * CB
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctl_t     ctl,
  input  logic [RW-1:0] lo_rec,
  input  logic [RW-1:0] hi_rec,
  output logic [RW-1:0] rec
);

  localparam int KW = 2 + OW + CB + OW;
  localparam logic PAR = ((IDX % 2) == 1);

  typedef struct packed {
    logic          valid;
    logic          horiz;
    logic [OW-1:0] order;
    logic [OW-1:0] gid;
    logic [CB-1:0] x0;
    logic [CB-1:0] y0;
    logic [CB-1:0] x1;
    logic [CB-1:0] y1;
  } rec_t;

  function automatic logic [KW-1:0] key_of(rec_t r, logic sel);
    logic [CB-1:0] main_c;
    logic [CB-1:0] minor_c;
    main_c = r.horiz ? r.y0 : r.x0;
    minor_c = r.horiz ? r.x0 : r.y0;
    if (sel) begin
      key_of = {~r.valid, r.horiz, r.gid, minor_c, r.order};
    end else begin
      key_of = {~r.valid, r.horiz, {OW{1'b0}}, main_c, r.order};
    end
  endfunction

  rec_t cur;
  rec_t lo;
  rec_t hi;
  rec_t cur_next;
  logic lower_role;
  logic upper_role;

  assign lo = rec_t'(lo_rec);
  assign hi = rec_t'(hi_rec);
  assign rec = cur;

  assign lower_role = (ctl.phase == PAR) && (IDX < N - 1);
  assign upper_role = (ctl.phase != PAR) && (IDX > 0);

  always_comb begin
    cur_next = cur;
    case (ctl.op)
      CELL_PUSH: cur_next = lo;
      CELL_POP:  cur_next = hi;
      CELL_SORT: begin
        if (lower_role && (key_of(cur, ctl.key_sel) > key_of(hi, ctl.key_sel))) begin
          cur_next = hi;
        end else if (upper_role && (key_of(lo, ctl.key_sel) > key_of(cur, ctl.key_sel))) begin
          cur_next = lo;
        end
      end
      default: cur_next = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else begin
      cur <= cur_next;
    end
  end

endmodule

// File: src/line_segment_group_merge_core.sv
// Line segment grouping and merging.
// Input channel seg_*: one segment per accepted item (seg_valid high, seg_stall
// low). Kept segments enter a row of sorting cells at one item per cycle while seg_stall is low.
// An item with final_segment set closes the set and starts a run; seg_stall
// stays high until the run has been handed to the output register.
// A run does odd-even sorting of the cell row by main axis, numbers the groups
// while popping each stored segment round the row, sorts again by group and
// cross axis, then walks the stored segments to merge and emit them.
// Output channel res_*: one merged segment per item, vertical groups first,
// run_end on the last. An empty set gives one item with no_segments set.
// A stalled result holds in the output register and the emit walk pauses.
// Configuration writes via cfg_write/cfg_index/cfg_data, only while idle.
// rst (synchronous, active high) empties the store, clears the count and
// overflow flag and restores the registers to 1024, 1024 and 6.
module line_segment_group_merge_core
  import lsgm_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  seg_valid,
  output logic                  seg_stall,
  input  logic [COORD_BITS-1:0] end_a_x,
  input  logic [COORD_BITS-1:0] end_a_y,
  input  logic [COORD_BITS-1:0] end_b_x,
  input  logic [COORD_BITS-1:0] end_b_y,
  input  logic                  final_segment,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic                  is_horizontal,
  output logic [GRP_OUT_W-1:0]  group_index,
  output logic [COORD_BITS-1:0] start_x,
  output logic [COORD_BITS-1:0] start_y,
  output logic [COORD_BITS-1:0] stop_x,
  output logic [COORD_BITS-1:0] stop_y,
  output logic                  no_segments,
  output logic                  store_overflow,
  output logic                  run_end
);

  localparam int CB = COORD_BITS;
  localparam int OW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int RW = 2 + 2 * OW + 4 * CB;
  localparam int EW = ((CB > CFG_W) ? CB : CFG_W) + 1;
  localparam int SW = CB + 2;

  typedef struct packed {
    logic          valid;
    logic          horiz;
    logic [OW-1:0] order;
    logic [OW-1:0] gid;
    logic [CB-1:0] x0;
    logic [CB-1:0] y0;
    logic [CB-1:0] x1;
    logic [CB-1:0] y1;
  } rec_t;

  state_t state;
  state_t state_next;
  cell_ctl_t ctl;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [GAP_W-1:0] group_gap;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt;
  logic overflow_seen;

  logic [RW-1:0] cell_q [MAX_SEGMENTS];
  rec_t push_rec;
  rec_t tail_rec;
  rec_t head;

  logic out_free;
  logic res_load;
  logic accept;

  // classification
  logic [CB-1:0] dx;
  logic [CB-1:0] dy;
  logic vert_ok;
  logic horiz_ok;
  logic keep;
  logic store;
  logic [CNT_W-1:0] count_inc;

  function automatic logic in_range(logic [CB-1:0] v, logic [CFG_W-1:0] lim);
    logic [EW-1:0] ve;
    logic [EW-1:0] le;
    ve = EW'(v);
    le = EW'(lim);
    in_range = (ve > EW'(EDGE_MARGIN)) && ((ve + EW'(EDGE_MARGIN)) < le);
  endfunction

  assign dx = (end_a_x > end_b_x) ? (end_a_x - end_b_x) : (end_b_x - end_a_x);
  assign dy = (end_a_y > end_b_y) ? (end_a_y - end_b_y) : (end_b_y - end_a_y);
  assign vert_ok = (dx < CB'(AXIS_SLACK)) && in_range(end_a_x, image_width) &&
                   in_range(end_b_x, image_width);
  assign horiz_ok = !vert_ok && (dy < CB'(AXIS_SLACK)) &&
                    in_range(end_a_y, image_height) && in_range(end_b_y, image_height);
  assign keep = vert_ok || horiz_ok;
  assign store = keep && (count < CNT_W'(MAX_SEGMENTS));
  assign count_inc = store ? CNT_W'(count + 1'b1) : count;

  always_comb begin
    push_rec = '0;
    push_rec.valid = 1'b1;
    push_rec.horiz = horiz_ok;
    push_rec.order = OW'(count);
    if (vert_ok) begin
      if (end_a_y < end_b_y) begin
        push_rec.x0 = end_a_x;
        push_rec.y0 = end_a_y;
        push_rec.x1 = end_a_x;
        push_rec.y1 = end_b_y;
      end else begin
        push_rec.x0 = end_b_x;
        push_rec.y0 = end_b_y;
        push_rec.x1 = end_a_x;
        push_rec.y1 = end_a_y;
      end
    end else begin
      if (end_a_x < end_b_x) begin
        push_rec.x0 = end_a_x;
        push_rec.y0 = end_a_y;
        push_rec.x1 = end_b_x;
        push_rec.y1 = end_a_y;
      end else begin
        push_rec.x0 = end_b_x;
        push_rec.y0 = end_b_y;
        push_rec.x1 = end_a_x;
        push_rec.y1 = end_a_y;
      end
    end
  end

  // cell row
  assign head = rec_t'(cell_q[0]);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
      logic [RW-1:0] lo_rec;
      logic [RW-1:0] hi_rec;
      if (gi == 0) begin : g_first
        assign lo_rec = push_rec;
      end else begin : g_mid_lo
        assign lo_rec = cell_q[gi-1];
      end
      if (gi == MAX_SEGMENTS - 1) begin : g_last
        assign hi_rec = tail_rec;
      end else begin : g_mid_hi
        assign hi_rec = cell_q[gi+1];
      end
      lsgm_cell #(
        .IDX(gi),
        .N  (MAX_SEGMENTS),
        .CB (CB),
        .OW (OW)
      ) u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .lo_rec(lo_rec),
        .hi_rec(hi_rec),
        .rec   (cell_q[gi])
      );
    end
  endgenerate

  // group numbering
  logic g_first;
  logic g_h;
  logic [CB-1:0] g_main;
  logic [OW-1:0] g_id;
  logic [CB-1:0] head_main;
  logic new_group;
  logic [OW-1:0] gid_new;

  assign head_main = head.horiz ? head.y0 : head.x0;
  assign new_group = (CB + 1)'(head_main - g_main) >= (CB + 1)'(group_gap);
  assign gid_new = (g_first || (head.horiz != g_h)) ? '0 :
                   (new_group ? OW'(g_id + 1'b1) : g_id);

  always_comb begin
    tail_rec = '0;
    if (state == ST_GROUP) begin
      tail_rec = head;
      tail_rec.gid = gid_new;
    end
  end

  // merge
  rec_t cur;
  rec_t merged;
  logic [NEAR_W-1:0] near;
  logic [CB-1:0] cs;
  logic [CB-1:0] nf;
  logic [CB-1:0] ns;
  logic join_ok;

  assign near = head.horiz ? NEAR_W'(group_gap) : NEAR_W'({group_gap, 1'b0});
  assign cs = cur.horiz ? cur.x1 : cur.y1;
  assign nf = head.horiz ? head.x0 : head.y0;
  assign ns = head.horiz ? head.x1 : head.y1;
  assign join_ok = cur.valid && (cur.horiz == head.horiz) && (cur.gid == head.gid) &&
                   (SW'(nf) <= (SW'(cs) + SW'(near)));

  always_comb begin
    merged = cur;
    if (ns > cs) begin
      if (cur.horiz) begin
        merged.x1 = ns;
      end else begin
        merged.y1 = ns;
      end
    end
  end

  assign out_free = !res_valid || !res_stall;
  assign res_load = out_free && ((state == ST_EMPTY) ||
                    ((state == ST_EMIT) && ((cnt == count) || (!join_ok && cur.valid))));
  assign seg_stall = (state != ST_LOAD);
  assign accept = seg_valid && !seg_stall;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op = CELL_HOLD;
    ctl.phase = cnt[0];
    ctl.key_sel = 1'b0;
    case (state)
      ST_LOAD: begin
        if (seg_valid) begin
          if (store) begin
            ctl.op = CELL_PUSH;
          end
          if (final_segment) begin
            state_next = (count_inc == '0) ? ST_EMPTY : ST_SORT_MAIN;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
      ST_SORT_MAIN: begin
        ctl.op = CELL_SORT;
        if (cnt == CNT_W'(MAX_SEGMENTS - 1)) begin
          state_next = ST_GROUP;
        end
      end
      ST_GROUP: begin
        ctl.op = CELL_POP;
        if (CNT_W'(cnt + 1'b1) == count) begin
          state_next = ST_SORT_CROSS;
        end
      end
      ST_SORT_CROSS: begin
        ctl.op = CELL_SORT;
        ctl.key_sel = 1'b1;
        if (cnt == CNT_W'(MAX_SEGMENTS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (cnt != count) begin
            ctl.op = CELL_POP;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      group_gap <= GROUP_GAP_RST;
      count <= '0;
      cnt <= '0;
      overflow_seen <= 1'b0;
      res_valid <= 1'b0;
      cur.valid <= 1'b0;
      g_first <= 1'b1;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          REG_GROUP_GAP:    group_gap <= cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end

      if (state_next != state) begin
        cnt <= '0;
      end else if (ctl.op != CELL_HOLD) begin
        cnt <= CNT_W'(cnt + 1'b1);
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_LOAD: begin
          if (accept) begin
            count <= count_inc;
            if (keep && !store) begin
              overflow_seen <= 1'b1;
            end
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            is_horizontal <= 1'b0;
            group_index <= '0;
            start_x <= '0;
            start_y <= '0;
            stop_x <= '0;
            stop_y <= '0;
            no_segments <= 1'b1;
            store_overflow <= overflow_seen;
            run_end <= 1'b1;
            overflow_seen <= 1'b0;
            count <= '0;
          end
        end
        ST_SORT_MAIN: begin
          g_first <= 1'b1;
        end
        ST_GROUP: begin
          g_first <= 1'b0;
          g_h <= head.horiz;
          g_main <= head_main;
          g_id <= gid_new;
        end
        ST_SORT_CROSS: begin
          cur.valid <= 1'b0;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (cnt != count) begin
              if (join_ok) begin
                cur <= merged;
              end else begin
                if (cur.valid) begin
                  is_horizontal <= cur.horiz;
                  group_index <= GRP_OUT_W'(cur.gid);
                  start_x <= cur.x0;
                  start_y <= cur.y0;
                  stop_x <= cur.x1;
                  stop_y <= cur.y1;
                  no_segments <= 1'b0;
                  store_overflow <= overflow_seen;
                  run_end <= 1'b0;
                end
                cur <= head;
              end
            end else begin
              is_horizontal <= cur.horiz;
              group_index <= GRP_OUT_W'(cur.gid);
              start_x <= cur.x0;
              start_y <= cur.y0;
              stop_x <= cur.x1;
              stop_y <= cur.y1;
              no_segments <= 1'b0;
              store_overflow <= overflow_seen;
              run_end <= 1'b1;
              cur.valid <= 1'b0;
              overflow_seen <= 1'b0;
              count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond store depth");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && no_segments |-> run_end)
    else $error("empty-set item not marked last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && no_segments |-> (start_x == '0) && (stop_y == '0) && !is_horizontal)
    else $error("empty-set item carries data");

  a_load_only: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && (cnt != count) |-> (cur.valid || (cnt == '0)))
    else $error("merge register empty during walk");

endmodule

// File: test/lsgm_checker.sv
`timescale 1ns / 100ps
module lsgm_checker
  import lsgm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 seg_valid,
  input  logic                 seg_stall,
  input  logic [11:0]          end_a_x,
  input  logic [11:0]          end_a_y,
  input  logic [11:0]          end_b_x,
  input  logic [11:0]          end_b_y,
  input  logic                 final_segment,
  input  logic                 res_valid,
  input  logic                 res_stall,
  input  logic                 is_horizontal,
  input  logic [5:0]           group_index,
  input  logic [11:0]          start_x,
  input  logic [11:0]          start_y,
  input  logic [11:0]          stop_x,
  input  logic [11:0]          stop_y,
  input  logic                 no_segments,
  input  logic                 store_overflow,
  input  logic                 run_end,
  output int                   fail_count,
  output int                   pending
);

  localparam int DEPTH = 64;

  typedef struct {
    int x0, y0, x1, y1;
    bit horiz;
    int order;
  } line_t;

  typedef struct packed {
    logic       horiz;
    logic [5:0] grp;
    logic [11:0] sx, sy, ex, ey;
    logic       none, ovf, last;
  } merged_t;

  line_t   kept[DEPTH];
  line_t   work[DEPTH];
  line_t   grp_segs[DEPTH];
  int      grp_id[DEPTH];
  int      kept_count;
  bit      dropped_full;
  int      img_w, img_h, gap;
  merged_t merged_q[$];
  merged_t run_out[$];

  assign pending = merged_q.size();

  function automatic bit within_edge(int v, int lim);
    return v > EDGE_MARGIN && v < lim - EDGE_MARGIN;
  endfunction

  function automatic int adiff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  task automatic keep_line(int x0, int y0, int x1, int y1, bit h);
    if (kept_count >= DEPTH) begin
      dropped_full = 1;
    end else begin
      kept[kept_count] = '{x0, y0, x1, y1, h, kept_count};
      kept_count++;
    end
  endtask

  function automatic int lead_key(line_t s, bit by_x);
    return by_x ? s.x0 : s.y0;
  endfunction

  task automatic sort_lines(ref line_t a[DEPTH], input int lo, input int n, input bit by_x);
    line_t t;
    int j;
    for (int i = lo + 1; i < lo + n; i++) begin
      t = a[i];
      j = i;
      while (j > lo && (lead_key(a[j-1], by_x) > lead_key(t, by_x) ||
             (lead_key(a[j-1], by_x) == lead_key(t, by_x) && a[j-1].order > t.order))) begin
        a[j] = a[j-1];
        j--;
      end
      a[j] = t;
    end
  endtask

  task automatic merge_lines(input int n_in, input bit h, output int n_out);
    int near, i, n, cs, nf, ns;
    bit drop;
    near = h ? gap : 2 * gap;
    n = n_in;
    i = 0;
    while (n > 1 && i + 1 < n) begin
      cs = h ? grp_segs[i].x1 : grp_segs[i].y1;
      nf = h ? grp_segs[i+1].x0 : grp_segs[i+1].y0;
      ns = h ? grp_segs[i+1].x1 : grp_segs[i+1].y1;
      drop = 0;
      if (cs >= ns) begin
        drop = 1;
      end else if (cs >= nf && cs <= ns) begin
        cs = ns;
        drop = 1;
      end else if (cs <= nf && nf - cs <= near) begin
        cs = ns;
        drop = 1;
      end
      if (drop) begin
        if (h) grp_segs[i].x1 = cs;
        else grp_segs[i].y1 = cs;
        for (int j = i + 1; j < n - 1; j++) grp_segs[j] = grp_segs[j+1];
        n--;
        i = 0;
      end else begin
        i++;
      end
    end
    n_out = n;
  endtask

  task automatic emit_side(bit h);
    int n, gs, ge, m, gid;
    merged_t r;
    n = 0;
    for (int i = 0; i < kept_count; i++)
      if (kept[i].horiz == h) begin
        work[n] = kept[i];
        n++;
      end
    if (n == 0) return;
    sort_lines(work, 0, n, !h);
    gid = 0;
    grp_id[0] = 0;
    for (int i = 1; i < n; i++) begin
      if (lead_key(work[i], h ? 1'b0 : 1'b1) - lead_key(work[i-1], h ? 1'b0 : 1'b1) >= gap)
        gid++;
      grp_id[i] = gid;
    end
    gs = 0;
    while (gs < n) begin
      ge = gs + 1;
      while (ge < n && grp_id[ge] == grp_id[gs]) ge++;
      sort_lines(work, gs, ge - gs, h);
      for (int j = 0; j < ge - gs; j++) grp_segs[j] = work[gs + j];
      merge_lines(ge - gs, h, m);
      for (int j = 0; j < m && run_out.size() < DEPTH; j++) begin
        r = '0;
        r.horiz = h;
        r.grp = grp_id[gs][5:0];
        r.sx = grp_segs[j].x0[11:0];
        r.sy = grp_segs[j].y0[11:0];
        r.ex = grp_segs[j].x1[11:0];
        r.ey = grp_segs[j].y1[11:0];
        r.ovf = dropped_full;
        run_out.insert(run_out.size(), r);
      end
      gs = ge;
    end
  endtask

  task automatic take_line(int ax, int ay, int bx, int by, bit fin);
    merged_t r;
    if (adiff(ax, bx) < AXIS_SLACK && within_edge(ax, img_w) && within_edge(bx, img_w)) begin
      if (ay < by) keep_line(ax, ay, ax, by, 0);
      else keep_line(bx, by, ax, ay, 0);
    end else if (adiff(ay, by) < AXIS_SLACK && within_edge(ay, img_h) &&
                 within_edge(by, img_h)) begin
      if (ax < bx) keep_line(ax, ay, bx, ay, 1);
      else keep_line(bx, by, ax, ay, 1);
    end
    if (!fin) return;
    run_out.delete();
    if (kept_count == 0) begin
      r = '0;
      r.none = 1;
      r.ovf = dropped_full;
      run_out.insert(run_out.size(), r);
    end else begin
      emit_side(0);
      emit_side(1);
    end
    run_out[run_out.size() - 1].last = 1;
    foreach (run_out[i]) merged_q.insert(merged_q.size(), run_out[i]);
    kept_count = 0;
    dropped_full = 0;
  endtask

  always @(posedge clk) begin
    merged_t got, want;
    if (rst) begin
      kept_count <= 0;
      dropped_full <= 0;
      img_w <= int'(IMAGE_WIDTH_RST);
      img_h <= int'(IMAGE_HEIGHT_RST);
      gap <= int'(GROUP_GAP_RST);
      merged_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: img_w = int'(cfg_data);
          REG_IMAGE_HEIGHT: img_h = int'(cfg_data);
          REG_GROUP_GAP: gap = int'(cfg_data[GAP_W-1:0]);
          default: ;
        endcase
      end
      if (seg_valid && !seg_stall)
        take_line(end_a_x, end_a_y, end_b_x, end_b_y, final_segment);
      if (res_valid && !res_stall) begin
        got = {is_horizontal, group_index, start_x, start_y, stop_x, stop_y,
               no_segments, store_overflow, run_end};
        if (merged_q.size() == 0) begin
          $display("%0t: unexpected item, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = merged_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected h=%0d g=%0d (%0d,%0d)-(%0d,%0d) n=%0d o=%0d e=%0d",
                     $time, want.horiz, want.grp, want.sx, want.sy, want.ex, want.ey,
                     want.none, want.ovf, want.last);
            $display("%0t:          actual   h=%0d g=%0d (%0d,%0d)-(%0d,%0d) n=%0d o=%0d e=%0d",
                     $time, got.horiz, got.grp, got.sx, got.sy, got.ex, got.ey,
                     got.none, got.ovf, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: test/tb_line_segment_group_merge_core.sv
`timescale 1ns / 100ps
module tb_line_segment_group_merge_core;
  import lsgm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 seg_valid;
  logic                 seg_stall;
  logic [11:0]          end_a_x, end_a_y, end_b_x, end_b_y;
  logic                 final_segment;
  logic                 res_valid;
  logic                 res_stall;
  logic                 is_horizontal;
  logic [5:0]           group_index;
  logic [11:0]          start_x, start_y, stop_x, stop_y;
  logic                 no_segments, store_overflow, run_end;
  int                   fail_count, pending;
  int                   cycles;
  int                   img_w, img_h;
  int                   random_items;
  bit                   hold_request;
  bit                   busy_sender;

  line_segment_group_merge_core u_dut (.*);

  lsgm_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    res_stall <= 0;
    forever begin
      r = $urandom_range(0, 99);
      if (hold_request) begin
        hold_request = 0;
        res_stall <= 1;
        repeat (500) @(posedge clk);
      end else if (r < 50) begin
        res_stall <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (r < 88) begin
        res_stall <= 1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 93) begin
        res_stall <= 1;
        repeat ($urandom_range(15, 40)) @(posedge clk);
      end else begin
        res_stall <= 0;
        repeat ($urandom_range(40, 80)) @(posedge clk);
      end
    end
  end

  task automatic send_line(int ax, int ay, int bx, int by, bit fin);
    int g, r;
    r = $urandom_range(0, 99);
    g = busy_sender ? 0 : (r < 60 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(15, 40)));
    if (g > 0) begin
      seg_valid <= 0;
      repeat (g) @(posedge clk);
    end
    seg_valid <= 1;
    end_a_x <= ax[11:0];
    end_a_y <= ay[11:0];
    end_b_x <= bx[11:0];
    end_b_y <= by[11:0];
    final_segment <= fin;
    do @(posedge clk); while (seg_stall);
  endtask

  task automatic settle;
    seg_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_regs(int w, int h, int g);
    cfg_write <= 1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_GROUP_GAP;
    cfg_data <= g[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
    img_w = w;
    img_h = h;
  endtask

  task automatic random_set(int n);
    int base, ax, ay, bx, by, a0, a1;
    busy_sender = ($urandom_range(0, 3) == 0);
    base = (img_w > 60 && img_h > 60) ?
           $urandom_range(11, (img_w < img_h ? img_w : img_h) - 40) : 0;
    for (int i = 0; i < n; i++) begin
      if (base == 0 || $urandom_range(0, 9) < 2) begin
        ax = $urandom_range(0, 4095);
        ay = $urandom_range(0, 4095);
        bx = $urandom_range(0, 1) ? ax + $urandom_range(0, 6) - 3 : $urandom_range(0, 4095);
        by = $urandom_range(0, 4095);
        if (bx < 0) bx = 0;
        if (bx > 4095) bx = 4095;
      end else begin
        ax = base + $urandom_range(0, 3) * $urandom_range(0, 6);
        bx = ax + $urandom_range(0, 4);
        a0 = $urandom_range(11, 200);
        a1 = a0 + $urandom_range(0, 60);
        ay = $urandom_range(0, 1) ? a0 : a1;
        by = (ay == a0) ? a1 : a0;
        if ($urandom_range(0, 1)) begin
          int t;
          t = ax; ax = ay; ay = t;
          t = bx; bx = by; by = t;
        end
      end
      send_line(ax, ay, bx, by, i == n - 1);
      random_items++;
    end
    busy_sender = 0;
  endtask

  initial begin
    rst <= 1;
    cfg_write <= 0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    seg_valid <= 0;
    end_a_x <= '0;
    end_a_y <= '0;
    end_b_x <= '0;
    end_b_y <= '0;
    final_segment <= 0;
    cycles = 0;
    hold_request = 0;
    busy_sender = 0;
    random_items = 0;
    img_w = 1024;
    img_h = 1024;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_line(100, 100, 102, 300, 0);
    send_line(200, 400, 203, 150, 0);
    send_line(50, 500, 400, 502, 0);
    send_line(600, 700, 100, 698, 0);
    send_line(0, 0, 4095, 4095, 0);
    send_line(10, 100, 10, 200, 0);
    send_line(11, 100, 11, 200, 0);
    send_line(1013, 100, 1013, 200, 0);
    send_line(1014, 100, 1014, 200, 0);
    send_line(300, 1013, 350, 1013, 0);
    send_line(300, 100, 300, 200, 0);
    send_line(301, 150, 301, 180, 0);
    send_line(302, 190, 302, 260, 0);
    send_line(300, 270, 300, 280, 0);
    send_line(300, 300, 300, 320, 0);
    send_line(100, 800, 200, 800, 0);
    send_line(206, 801, 300, 801, 0);
    send_line(320, 802, 400, 802, 0);
    send_line(4095, 4095, 0, 0, 1);
    send_line(5, 5, 5, 5, 1);
    settle();

    busy_sender = 1;
    hold_request = 1;
    for (int i = 0; i < 68; i++)
      send_line(20 + 14 * i, 40 + i, 20 + 14 * i, 90 + 2 * i, i == 67);
    send_line(500, 100, 500, 300, 0);
    send_line(100, 500, 300, 500, 1);
    busy_sender = 0;
    settle();

    set_regs(4096, 4096, 255);
    while (random_items < 25) random_set($urandom_range(0, 5) == 0 ? 12 : $urandom_range(1, 6));
    settle();

    set_regs(1, 1, 0);
    send_line(2, 2, 2, 8, 0);
    send_line(4095, 0, 4095, 4095, 1);
    settle();

    set_regs(200, 300, 0);
    while (random_items < 45) random_set($urandom_range(1, 8));
    settle();

    set_regs($urandom_range(300, 4096), $urandom_range(300, 4096), $urandom_range(1, 40));
    while (random_items < 75) random_set($urandom_range(1, 10));
    settle();

    set_regs(1024, 1024, 6);
    while (random_items < 90) random_set($urandom_range(2, 8));
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
